/* rtl/scs_pkg.sv */
// Package for the additive sine synthesiser: item kinds, controller/datapath
// command and status structs, defaults and the quarter-wave sine function.
// No dependencies.
package scs_pkg;

    localparam int DEF_VOICES     = 8;
    localparam int DEF_FADE_LEN   = 200;
    localparam int DEF_TABLE_BITS = 10;
    localparam int DEF_COUNT_BITS = 20;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam logic [63:0] RAD_TO_PHASE = 64'd683565276;
    localparam logic [63:0] FULL_SCALE   = 64'd32767;

    typedef struct packed {
        logic load;
        logic start;
        logic seed;
        logic gain;
        logic amp;
        logic mul;
        logic div;
        logic acc;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic playing;
        logic last_voice;
    } t_sts;

    // Quarter-wave entry r of a table whose quarter is 2^qbits entries long.
    // Angle in Q30, Taylor series to x^13, rounded to 0..32767.
    function automatic logic [14:0] quarter_sine(input int r, input int qbits);
        logic [63:0]        x;
        logic [63:0]        t;
        logic signed [63:0] s;
        logic [63:0]        amp;
        x = (64'(r) * HALF_PI_Q30) >> qbits;
        t = x;
        s = signed'(x);
        t = (((t * x) >> 30) * x) >> 30;
        t = t / 64'd6;
        s = s - signed'(t);
        t = (((t * x) >> 30) * x) >> 30;
        t = t / 64'd20;
        s = s + signed'(t);
        t = (((t * x) >> 30) * x) >> 30;
        t = t / 64'd42;
        s = s - signed'(t);
        t = (((t * x) >> 30) * x) >> 30;
        t = t / 64'd72;
        s = s + signed'(t);
        t = (((t * x) >> 30) * x) >> 30;
        t = t / 64'd110;
        s = s - signed'(t);
        t = (((t * x) >> 30) * x) >> 30;
        t = t / 64'd156;
        s = s + signed'(t);
        if (s < 0) begin
            s = 64'sd0;
        end
        amp = (unsigned'(s) * FULL_SCALE + (64'd1 << 29)) >> 30;
        if (amp > FULL_SCALE) begin
            amp = FULL_SCALE;
        end
        return amp[14:0];
    endfunction

endpackage

/* rtl/scs_ctrl.sv */
// Controller for the sine synthesiser: input/output handshakes, voice and
// divider bit counters, and command sequencing. Depends on scs_pkg.
module scs_ctrl #(
    parameter int VOICES   = scs_pkg::DEF_VOICES,
    parameter int DIV_BITS = 16,
    localparam int JW = (VOICES > 1) ? $clog2(VOICES) : 1,
    localparam int BW = $clog2(DIV_BITS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [1:0]    i_kind,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  scs_pkg::t_sts i_sts,
    output scs_pkg::t_cmd o_cmd,
    output logic [JW-1:0] o_voice
);
    import scs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEED = 3'd1;
    localparam logic [2:0] S_GAIN = 3'd2;
    localparam logic [2:0] S_AMP  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_ACC  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [JW-1:0] r_voice, n_voice;
    logic [BW-1:0] r_bit, n_bit;
    logic          r_ovalid, n_ovalid;
    logic          w_acc_in;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc_in      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign o_voice       = r_voice;

    always_comb begin
        n_state  = r_state;
        n_voice  = r_voice;
        n_bit    = r_bit;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    case (i_kind)
                        KIND_LOAD: o_cmd.load = 1'b1;
                        KIND_START: begin
                            o_cmd.start = 1'b1;
                            n_voice     = '0;
                            n_state     = S_SEED;
                        end
                        KIND_TICK: begin
                            if (i_sts.playing) begin
                                n_state = S_GAIN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                if (i_sts.last_voice) begin
                    n_state = S_IDLE;
                end else begin
                    n_voice = r_voice + 1'b1;
                end
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_voice    = '0;
                n_state    = S_AMP;
            end
            S_AMP: begin
                o_cmd.amp = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_bit     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (r_bit == BW'(DIV_BITS - 1)) begin
                    n_state = S_ACC;
                end else begin
                    n_bit = r_bit + 1'b1;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.last_voice) begin
                    n_state = S_FIN;
                end else begin
                    n_voice = r_voice + 1'b1;
                    n_state = S_AMP;
                end
            end
            S_FIN: begin
                // hold the finished sample until the output register is free
                if (!r_ovalid || m_axis_tready) begin
                    o_cmd.fin = 1'b1;
                    n_ovalid  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_voice  <= '0;
            r_bit    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_voice  <= n_voice;
            r_bit    <= n_bit;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

/* rtl/scs_datapath.sv */
// Datapath for the sine synthesiser: voice step/phase registers, sine and
// seed tables, fade gain, multiplier, serial divider and mixer. Uses scs_pkg.
module scs_datapath #(
    parameter int VOICES     = scs_pkg::DEF_VOICES,
    parameter int FADE_LEN   = scs_pkg::DEF_FADE_LEN,
    parameter int TABLE_BITS = scs_pkg::DEF_TABLE_BITS,
    parameter int COUNT_BITS = scs_pkg::DEF_COUNT_BITS,
    localparam int JW = (VOICES > 1) ? $clog2(VOICES) : 1,
    localparam int GW = $clog2(FADE_LEN + 1),
    localparam int PW = 15 + GW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  scs_pkg::t_cmd i_cmd,
    input  logic [JW-1:0] i_voice,
    input  logic [2:0]    i_voice_index,
    input  logic [31:0]   i_phase_increment,
    input  logic [3:0]    i_voice_count,
    input  logic [19:0]   i_sample_count,
    output scs_pkg::t_sts o_sts,
    output logic [15:0]   o_sample,
    output logic          o_last
);
    import scs_pkg::*;

    localparam int VW      = $clog2(VOICES + 1);
    localparam int VW1     = VW + 1;
    localparam int CB      = COUNT_BITS;
    localparam int CB1     = COUNT_BITS + 1;
    localparam int DW      = $clog2(FADE_LEN * VOICES + 1);
    localparam int QB      = TABLE_BITS - 2;
    localparam int QUARTER = 1 << QB;
    localparam int RW      = TABLE_BITS - 1;

    logic [31:0]    r_step  [VOICES];
    logic [31:0]    r_phase [VOICES];
    logic [CB-1:0]  r_i, r_len;
    logic [VW-1:0]  r_n;
    logic           r_playing;
    logic [DW-1:0]  r_denom;
    logic [GW-1:0]  r_gain;
    logic [14:0]    r_mag;
    logic           r_neg;
    logic [PW-1:0]  r_quo;
    logic [DW-1:0]  r_rem;
    logic [15:0]    r_acc;
    logic [15:0]    r_sample;
    logic           r_last;

    logic [14:0]    w_qtab [QUARTER + 1];
    logic [31:0]    w_seed [VOICES][VOICES];

    for (genvar gr = 0; gr <= QUARTER; gr++) begin : g_qtab
        assign w_qtab[gr] = quarter_sine(gr, QB);
    end

    for (genvar gj = 0; gj < VOICES; gj++) begin : g_seed_j
        for (genvar gn = 1; gn <= VOICES; gn++) begin : g_seed_n
            localparam logic [63:0] SEED = (64'(gj) * RAD_TO_PHASE) / 64'(gn);
            assign w_seed[gj][gn-1] = SEED[31:0];
        end
    end

    logic [VW-1:0]        w_new_n;
    logic [GW-1:0]        w_gain;
    logic [TABLE_BITS-1:0] w_idx;
    logic [RW-1:0]        w_raddr;
    logic [DW:0]          w_trial;
    logic                 w_ge;
    logic                 w_last;
    logic [VW-1:0]        w_nm1;

    always_comb begin
        if (i_voice_count == 4'd0) begin
            w_new_n = VW'(1);
        end else if (int'(i_voice_count) > VOICES) begin
            w_new_n = VW'(VOICES);
        end else begin
            w_new_n = VW'(i_voice_count);
        end
    end

    always_comb begin
        if (r_i < CB'(FADE_LEN)) begin
            w_gain = GW'(r_i);
        end else if ({1'b0, r_i} + CB1'(FADE_LEN) > {1'b0, r_len}) begin
            w_gain = GW'(r_len - r_i);
        end else begin
            w_gain = GW'(FADE_LEN);
        end
    end

    // fold the phase into the quarter wave; odd quadrants run backwards
    assign w_idx   = r_phase[i_voice][31 -: TABLE_BITS];
    assign w_raddr = w_idx[TABLE_BITS-2] ? RW'(QUARTER) - RW'(w_idx[QB-1:0])
                                         : RW'(w_idx[QB-1:0]);

    assign w_trial = {r_rem, r_quo[PW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_denom});
    assign w_last  = ({1'b0, r_i} + CB1'(1) >= {1'b0, r_len});
    assign w_nm1   = r_n - 1'b1;

    assign o_sts.playing    = r_playing;
    assign o_sts.last_voice = (VW1'(i_voice) == VW1'(w_nm1));
    assign o_sample         = r_sample;
    assign o_last           = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VOICES; k++) begin
                r_step[k]  <= '0;
                r_phase[k] <= '0;
            end
            r_i       <= '0;
            r_len     <= '0;
            r_n       <= VW'(1);
            r_playing <= 1'b0;
            r_denom   <= DW'(FADE_LEN);
        end else begin
            if (i_cmd.load && (int'(i_voice_index) < VOICES)) begin
                r_step[JW'(i_voice_index)] <= i_phase_increment;
            end
            if (i_cmd.start) begin
                r_n       <= w_new_n;
                r_len     <= CB'(i_sample_count);
                r_i       <= '0;
                r_playing <= (CB'(i_sample_count) != '0);
                r_denom   <= DW'(FADE_LEN * int'(w_new_n));
            end
            if (i_cmd.seed) begin
                r_phase[i_voice] <= w_seed[i_voice][JW'(w_nm1)];
            end
            if (i_cmd.acc) begin
                r_phase[i_voice] <= r_phase[i_voice] + r_step[i_voice];
            end
            if (i_cmd.fin) begin
                r_i <= r_i + 1'b1;
                if (w_last) begin
                    r_playing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gain) begin
            r_gain <= w_gain;
            r_acc  <= '0;
        end
        if (i_cmd.amp) begin
            r_mag <= w_qtab[w_raddr];
            r_neg <= w_idx[TABLE_BITS-1];
        end
        if (i_cmd.mul) begin
            r_quo <= PW'(r_mag) * PW'(r_gain);
            r_rem <= '0;
        end
        if (i_cmd.div) begin
            // restoring division, one quotient bit a cycle
            r_rem <= w_ge ? DW'(w_trial - {1'b0, r_denom}) : DW'(w_trial);
            r_quo <= {r_quo[PW-2:0], w_ge};
        end
        if (i_cmd.acc) begin
            r_acc <= r_neg ? r_acc - r_quo[15:0] : r_acc + r_quo[15:0];
        end
        if (i_cmd.fin) begin
            r_sample <= r_acc;
            r_last   <= w_last;
        end
    end

endmodule

/* rtl/sine_chord_synth_with_fade.sv */
// Top level of the additive sine synthesiser with linear fade.
// Depends on scs_pkg, scs_ctrl and scs_datapath.
//
// Input stream (s_axis): tuser carries the item kind, tdata the payload.
// A load request writes one voice's 32-bit phase step. A start request sets
// the voice count and note length and seeds voices 0..N-1 one per cycle. A
// tick request while a note plays produces one sample on m_axis, with tlast
// on the note's final sample; a tick while idle is dropped.
// A sounding tick's sample turns valid in the same cycle as tready returns
// high for the next request: each voice runs through a table read, one
// multiply and a serial divider producing one quotient bit per cycle (23
// bits per voice at the default fade length).
// One request is in work at a time; tready is high only when idle.
// The output register holds a finished sample while the receiver stalls;
// a further request is still taken, and a second finished sample waits
// inside until the first is taken.
// Reset (synchronous, active low) clears steps, phases, note state and the
// output valid; the sine table is constant logic, so no fill is needed.
module sine_chord_synth_with_fade #(
    parameter int VOICES     = scs_pkg::DEF_VOICES,
    parameter int FADE_LEN   = scs_pkg::DEF_FADE_LEN,
    parameter int TABLE_BITS = scs_pkg::DEF_TABLE_BITS,
    parameter int COUNT_BITS = scs_pkg::DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // voice_index[2:0], phase_increment[34:3], voice_count[38:35],
    // sample_count[58:39], zero fill above
    input  logic [63:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sample[15:0]
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import scs_pkg::*;

    localparam int JW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int PW = 15 + $clog2(FADE_LEN + 1);

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [JW-1:0] w_voice;

    scs_ctrl #(
        .VOICES   (VOICES),
        .DIV_BITS (PW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_kind        (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd),
        .o_voice       (w_voice)
    );

    scs_datapath #(
        .VOICES     (VOICES),
        .FADE_LEN   (FADE_LEN),
        .TABLE_BITS (TABLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_voice           (w_voice),
        .i_voice_index     (s_axis_tdata[2:0]),
        .i_phase_increment (s_axis_tdata[34:3]),
        .i_voice_count     (s_axis_tdata[38:35]),
        .i_sample_count    (s_axis_tdata[58:39]),
        .o_sts             (w_sts),
        .o_sample          (m_axis_tdata),
        .o_last            (m_axis_tlast)
    );

endmodule

/* test/sine_chord_synth_with_fade_test.sv */
// Testbench for sine_chord_synth_with_fade: loads, starts and ticks go in on
// s_axis; every mixed sample is checked against a local model of the synth.
// Depends on scs_pkg and the synth RTL.
module sine_chord_synth_with_fade_test;
    import scs_pkg::*;

    localparam int NVOICE   = 8;
    localparam int FADE     = 200;
    localparam int TBITS    = 10;
    localparam int WD_LIMIT = 20000;
    localparam int N_ITEMS  = 650;

    typedef struct {
        logic [1:0]  kind;
        logic [2:0]  voice;
        logic [31:0] step;
        logic [3:0]  count;
        logic [19:0] length;
        bit          drain;  // hold until every sample has come back
    } t_req;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } t_smp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    sine_chord_synth_with_fade u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    t_req        pending[$];
    t_smp        samples_due[$];
    int          total_reqs;
    int          sent = 0;
    int          errors = 0;
    int          n_samples = 0;
    int          n_lasts = 0;
    bit          took = 1'b0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          quiet = 0;

    // synth model state
    int          sine_lut[1 << TBITS];
    logic [31:0] m_step[NVOICE];
    logic [31:0] m_phase[NVOICE];
    logic [19:0] m_index, m_len;
    int          m_voices;
    bit          m_playing;

    function automatic int qwave(int r);
        logic [63:0] x, term;
        longint      acc;
        logic [63:0] amp;
        x = (64'(r) * 64'd1686629713) / 64'(1 << (TBITS - 2));
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        amp = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (amp > 64'd32767) amp = 64'd32767;
        return int'(amp);
    endfunction

    // Applies one request to the model; a sounding tick queues its sample.
    task automatic synth_apply(input logic [1:0] kind, input logic [63:0] pay);
        int     n;
        longint gain, acc, a;
        t_smp   s;
        if (kind == KIND_LOAD) begin
            m_step[pay[2:0]] = pay[34:3];
        end else if (kind == KIND_START) begin
            n = int'(pay[38:35]);
            if (n == 0) n = 1;
            if (n > NVOICE) n = NVOICE;
            m_voices = n;
            m_len = pay[58:39];
            m_index = '0;
            for (int j = 0; j < n; j++)
                m_phase[j] = 32'((64'(j) * 64'd683565276) / 64'(n));
            m_playing = (m_len != 0);
        end else if (kind == KIND_TICK && m_playing) begin
            if (m_index < FADE) gain = longint'(m_index);
            else if (longint'(m_index) + FADE > longint'(m_len))
                gain = longint'(m_len) - longint'(m_index);
            else gain = FADE;
            acc = 0;
            for (int j = 0; j < m_voices; j++) begin
                a = sine_lut[m_phase[j] >> (32 - TBITS)];
                acc += (a * gain) / longint'(FADE * m_voices);
                m_phase[j] += m_step[j];
            end
            s.sample = acc[15:0];
            s.last = (longint'(m_index) + 1 >= longint'(m_len));
            m_index = m_index + 1'b1;
            if (s.last) m_playing = 1'b0;
            samples_due.push_back(s);
        end
    endtask

    function automatic int idle_pct(bit rx);
        if (sent < total_reqs / 3) return rx ? 84 : 26;
        if (sent < 2 * total_reqs / 3) return rx ? 26 : 84;
        return 0;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || took)) begin
            if (pending.size() > 0 && $urandom_range(99) >= idle_pct(0)
                && (!pending[0].drain || samples_due.size() == 0)) begin
                t_req r;
                r = pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= r.kind;
                s_axis_tdata <= {5'b0, r.length, r.count, r.step, r.voice};
                sent <= sent + 1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off once the stream is under way
    always @(negedge i_clk) begin
        if (!hold_done && sent == 40) begin
            hold_done <= 1'b1;
            hold_left <= 1500;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && ($urandom_range(99) >= idle_pct(1));
        end
    end

    // monitor: check outgoing samples, then feed accepted requests to the model
    always @(posedge i_clk) begin
        took <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (samples_due.size() == 0) begin
                    $display("%0t: unexpected sample %h last %b", $time,
                             m_axis_tdata, m_axis_tlast);
                    errors++;
                end else begin
                    t_smp e;
                    e = samples_due.pop_front();
                    if (e.sample !== m_axis_tdata || e.last !== m_axis_tlast) begin
                        $display("%0t: sample exp %h last %b, got %h last %b", $time,
                                 e.sample, e.last, m_axis_tdata, m_axis_tlast);
                        errors++;
                    end
                    n_samples++;
                    if (e.last) n_lasts++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                synth_apply(s_axis_tuser, s_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= WD_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, quiet);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic t_req mk(logic [1:0] k, logic [2:0] v, logic [31:0] st,
                                logic [3:0] c, logic [19:0] l);
        t_req r;
        r.kind = k; r.voice = v; r.step = st; r.count = c; r.length = l;
        r.drain = 1'b0;
        return r;
    endfunction

    function automatic t_req rnd(logic [1:0] k);
        return mk(k, 3'($urandom), $urandom, 4'($urandom), 20'($urandom));
    endfunction

    task automatic add_note(int voices, int len, int ticks);
        t_req r;
        for (int j = 0; j < $urandom_range(3); j++) pending.push_back(rnd(KIND_LOAD));
        r = rnd(KIND_START);
        r.count = 4'(voices);
        r.length = 20'(len);
        pending.push_back(r);
        for (int t = 0; t < ticks; t++) begin
            if ($urandom_range(19) == 0) pending.push_back(rnd(KIND_LOAD));
            pending.push_back(rnd(KIND_TICK));
        end
    endtask

    initial begin
        t_req r;
        int   len;
        for (int k = 0; k < (1 << TBITS); k++) begin
            int q, rr;
            q = k >> (TBITS - 2);
            rr = k & ((1 << (TBITS - 2)) - 1);
            sine_lut[k] = (q % 2) ? qwave((1 << (TBITS - 2)) - rr) : qwave(rr);
            if (q >= 2) sine_lut[k] = -sine_lut[k];
        end
        foreach (m_step[j]) begin
            m_step[j] = '0;
            m_phase[j] = '0;
        end
        m_index = '0; m_len = '0; m_voices = 1; m_playing = 1'b0;

        // directed part
        pending.push_back(rnd(KIND_TICK));                   // tick while idle
        pending.push_back(mk(KIND_LOAD, 0, 32'hFFFF_FFFF, 0, 0));
        pending.push_back(mk(KIND_LOAD, 7, 32'h0000_0000, 0, 0));
        pending.push_back(mk(KIND_LOAD, 1, 32'h0123_4567, 0, 0));
        pending.push_back(mk(KIND_START, 0, 0, 0, 1));        // zero count, one sample
        pending.push_back(rnd(KIND_TICK));
        pending.push_back(rnd(KIND_TICK));                   // idle again
        pending.push_back(mk(3, 3'h7, 32'hFFFF_FFFF, 4'hF, 20'hFFFFF)); // unused kind
        pending.push_back(mk(KIND_START, 0, 0, 4'hF, 3));    // count saturates
        pending.push_back(rnd(KIND_TICK));
        pending.push_back(mk(KIND_LOAD, 2, 32'h8000_0000, 0, 0)); // load mid-note
        pending.push_back(rnd(KIND_TICK));
        pending.push_back(mk(KIND_START, 0, 0, 3, 0));       // zero length
        pending.push_back(rnd(KIND_TICK));
        pending.push_back(mk(KIND_START, 0, 0, 8, 20'hFFFFF)); // longest note
        pending.push_back(rnd(KIND_TICK));
        pending.push_back(rnd(KIND_TICK));
        pending.push_back(mk(KIND_START, 0, 0, 2, 2));       // restart mid-note
        pending.push_back(rnd(KIND_TICK));
        pending.push_back(rnd(KIND_TICK));
        r = rnd(KIND_TICK);
        r.drain = 1'b1;
        pending.push_back(r);

        // random part: mostly whole notes, one with the full fade out
        add_note(1, 405, 405);
        while (pending.size() < N_ITEMS) begin
            if ($urandom_range(9) < 8) begin
                case ($urandom_range(19))
                    0:       len = $urandom_range(201, 250);
                    1:       len = $urandom_range(1 << 19, (1 << 20) - 1);
                    default: len = $urandom_range(0, 12);
                endcase
                add_note($urandom_range(15), len,
                         (len > 250) ? $urandom_range(4) : len + $urandom_range(2));
            end else begin
                pending.push_back(rnd(2'($urandom)));
            end
            if ($urandom_range(15) == 0) pending[pending.size() - 1].drain = 1'b1;
        end
        total_reqs = pending.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
        wait (pending.size() == 0 && !s_axis_tvalid);
        wait (samples_due.size() == 0);
        repeat (300) @(posedge i_clk);
        $display("%0d requests sent, %0d samples checked, %0d note ends",
                 total_reqs, n_samples, n_lasts);
        if (errors == 0 && samples_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/scs_pkg.sv
rtl/scs_ctrl.sv
rtl/scs_datapath.sv
rtl/sine_chord_synth_with_fade.sv
test/sine_chord_synth_with_fade_test.sv
